// ----- sv/dfwf_pkg.sv -----
// Shared constants, types and helpers of the dark fringe window filter.
package dfwf_pkg;

  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned POS_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
  localparam int unsigned LAT_W      = CFG_W + 1;
  localparam int unsigned WIN        = 5;

  localparam int unsigned DARK_LIMIT = 48;
  localparam int unsigned QUAL_ALPHA = 200;
  localparam int unsigned ROUND_ADD  = 127;
  localparam int unsigned OPAQUE     = 255;

  localparam int unsigned UF_W       = 16;
  localparam int unsigned U_W        = 9;
  localparam int unsigned RSUM_W     = 11;
  localparam int unsigned SUM_W      = 13;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned RCNT_W     = 3;
  localparam int unsigned NMAX       = WIN * WIN - 1;

  localparam int unsigned RA_SHIFT   = 24;
  localparam int unsigned RA_W       = RA_SHIFT + 1;
  localparam int unsigned RN_SHIFT   = 18;
  localparam int unsigned RN_W       = RN_SHIFT + 1;
  localparam int unsigned RD_SHIFT   = 25;
  localparam int unsigned RD_W       = 18;
  localparam int unsigned RECIP_255  = ((1 << RD_SHIFT) + OPAQUE - 1) / OPAQUE;
  localparam int unsigned VV_W       = 17;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t                 pix;
    logic                 qual;
    logic                 dark;
    logic [2:0][U_W-1:0]  u;
  } tap_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             bypass;
    logic [WIN-1:0]   colok;
    logic [WIN-1:0]   rowok;
  } ctl_t;

  typedef struct packed {
    logic          en;
    logic          push;
    logic [XW-1:0] rd_addr;
    logic [XW-1:0] wr_addr;
  } win_ctl_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- sv/dark_fringe_window_filter_core.sv -----
// Top level of the dark fringe window filter core.
// The core takes one pixel beat per clock and has no internal rate limit: a frame is
// width*height pixel beats followed by 2*width+2 padding beats, and each beat from number
// 2*width+2 on returns one filtered pixel, so a pixel leaves 2*width+2 beats after it
// arrived, plus the pipeline registers. Four simple dual-port line buffers of MAX_WIDTH
// entries feed a 5x5 window; back pressure on the output stalls the whole pipeline.
// The frame size is sampled on the first beat of each frame.
module dark_fringe_window_filter_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // blue, green, red, alpha
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // out_blue, out_green, out_red, out_alpha
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [dfwf_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned CW = dfwf_pkg::CFG_W;
  localparam int unsigned W5 = dfwf_pkg::WIN;

  logic [dfwf_pkg::RA_W-1:0] recip_a [256];
  logic [dfwf_pkg::RN_W-1:0] recip_n [dfwf_pkg::NMAX+1];

  assign recip_a[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_ra
    localparam longint unsigned M = ((64'd1 << dfwf_pkg::RA_SHIFT) + i - 1) / i;
    assign recip_a[i] = dfwf_pkg::RA_W'(M);
  end
  assign recip_n[0] = '0;
  for (genvar i = 1; i <= dfwf_pkg::NMAX; i++) begin : g_rn
    localparam longint unsigned M = ((64'd1 << dfwf_pkg::RN_SHIFT) + i - 1) / i;
    assign recip_n[i] = dfwf_pkg::RN_W'(M);
  end

  logic [CW-1:0] frame_width_r, frame_height_r, act_w_r, act_h_r, w_eff, h_eff;
  logic [dfwf_pkg::POS_W-1:0] t_r;
  logic [dfwf_pkg::XW-1:0] xin_r, xc_r;
  logic [dfwf_pkg::YW-1:0] yc_r;
  logic [dfwf_pkg::LAT_W-1:0] lat;
  logic en, in_fire, emit, xc_last, yc_last, xin_last;
  dfwf_pkg::ctl_t ctl0;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (t_r == '0) begin
      w_eff = dfwf_pkg::clamp_dim(frame_width_r, CW'(dfwf_pkg::MAX_WIDTH));
      h_eff = dfwf_pkg::clamp_dim(frame_height_r, CW'(dfwf_pkg::MAX_HEIGHT));
    end else begin
      w_eff = act_w_r;
      h_eff = act_h_r;
    end
    lat      = {w_eff, 1'b0} + dfwf_pkg::LAT_W'(2);
    emit     = t_r >= dfwf_pkg::POS_W'(lat);
    xc_last  = {1'b0, xc_r} == w_eff - CW'(1);
    yc_last  = {1'b0, yc_r} == h_eff - CW'(1);
    xin_last = {1'b0, xin_r} == w_eff - CW'(1);
    ctl0.emit   = emit;
    ctl0.last   = emit && xc_last && yc_last;
    ctl0.bypass = (w_eff < CW'(3)) || (h_eff < CW'(3));
    ctl0.colok[0] = ({1'b0, xc_r} + CW'(2)) < w_eff;
    ctl0.colok[1] = ({1'b0, xc_r} + CW'(1)) < w_eff;
    ctl0.colok[2] = 1'b1;
    ctl0.colok[3] = xc_r != '0;
    ctl0.colok[4] = xc_r > dfwf_pkg::XW'(1);
    ctl0.rowok[0] = ({1'b0, yc_r} + CW'(2)) < h_eff;
    ctl0.rowok[1] = ({1'b0, yc_r} + CW'(1)) < h_eff;
    ctl0.rowok[2] = 1'b1;
    ctl0.rowok[3] = yc_r != '0;
    ctl0.rowok[4] = yc_r > dfwf_pkg::YW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CW'(64);
      frame_height_r <= CW'(64);
      act_w_r        <= CW'(64);
      act_h_r        <= CW'(64);
      t_r            <= '0;
      xin_r          <= '0;
      xc_r           <= '0;
      yc_r           <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (dfwf_pkg::reg_idx_t'(cfg_index))
          dfwf_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          dfwf_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        if (t_r == '0) begin
          act_w_r <= w_eff;
          act_h_r <= h_eff;
        end
        if (ctl0.last) begin
          t_r   <= '0;
          xin_r <= '0;
          xc_r  <= '0;
          yc_r  <= '0;
        end else begin
          t_r   <= t_r + dfwf_pkg::POS_W'(1);
          xin_r <= xin_last ? '0 : xin_r + dfwf_pkg::XW'(1);
          if (emit) begin
            if (xc_last) begin
              xc_r <= '0;
              yc_r <= yc_r + dfwf_pkg::YW'(1);
            end else begin
              xc_r <= xc_r + dfwf_pkg::XW'(1);
            end
          end
        end
      end
    end
  end

  dfwf_pkg::ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r, ctl5_r, ctl6_r, ctl7_r;

  // Pipeline valid bits.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_tvalid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r && ctl7_r.emit;
    end
  end

  // Stage 1: unpremultiply through a reciprocal of alpha.
  dfwf_pkg::pix_t pix1_r, pix2_r;
  logic [dfwf_pkg::XW-1:0] x1_r, x2_r;
  logic [2:0][dfwf_pkg::UF_W-1:0] u2_r, u_nxt;

  always_comb begin
    logic [7:0]                  ch [3];
    logic [dfwf_pkg::UF_W-1:0]   num;
    logic [dfwf_pkg::UF_W+dfwf_pkg::RA_W-1:0] prod;
    ch[0] = pix1_r.blue;
    ch[1] = pix1_r.green;
    ch[2] = pix1_r.red;
    for (int k = 0; k < 3; k++) begin
      num  = dfwf_pkg::UF_W'(ch[k]) * dfwf_pkg::UF_W'(255)
           + dfwf_pkg::UF_W'(pix1_r.alpha[7:1]);
      prod = (dfwf_pkg::UF_W + dfwf_pkg::RA_W)'(num)
           * (dfwf_pkg::UF_W + dfwf_pkg::RA_W)'(recip_a[pix1_r.alpha]);
      u_nxt[k] = prod[dfwf_pkg::RA_SHIFT +: dfwf_pkg::UF_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= ctl0;
      pix1_r <= dfwf_pkg::pix_t'(in_tdata);
      x1_r   <= xin_r;
      ctl2_r <= ctl1_r;
      pix2_r <= pix1_r;
      x2_r   <= x1_r;
      u2_r   <= u_nxt;
    end
  end

  // Stage 2: classify the pixel and push it into the window.
  dfwf_pkg::tap_t tap2;
  dfwf_pkg::win_ctl_t wctl;
  dfwf_pkg::tap_t [W5-1:0][W5-1:0] win;
  logic [dfwf_pkg::UF_W+1:0] usum2;

  always_comb begin
    usum2 = (dfwf_pkg::UF_W+2)'(u2_r[0]) + (dfwf_pkg::UF_W+2)'(u2_r[1])
          + (dfwf_pkg::UF_W+2)'(u2_r[2]);
    tap2.pix  = pix2_r;
    tap2.qual = pix2_r.alpha >= 8'(dfwf_pkg::QUAL_ALPHA);
    tap2.dark = (pix2_r.alpha != '0) && (pix2_r.alpha != 8'(dfwf_pkg::OPAQUE))
             && (usum2 <= (dfwf_pkg::UF_W+2)'(dfwf_pkg::DARK_LIMIT));
    for (int k = 0; k < 3; k++) begin
      tap2.u[k] = u2_r[k][dfwf_pkg::U_W-1:0];
    end
    wctl.en      = en;
    wctl.push    = en && v2_r;
    wctl.rd_addr = x1_r;
    wctl.wr_addr = x2_r;
  end

  dfwf_window u_window (
    .clk    (clk),
    .ctl    (wctl),
    .tap_in (tap2),
    .win    (win)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ctl3_r <= ctl2_r;
    end
  end

  // Stage 3: masked row sums over the window.
  logic [W5-1:0][2:0][dfwf_pkg::RSUM_W-1:0] rsum_nxt, rsum4_r;
  logic [W5-1:0][dfwf_pkg::RCNT_W-1:0] rcnt_nxt, rcnt4_r;
  dfwf_pkg::pix_t cpix4_r, cpix5_r, cpix6_r, cpix7_r;
  logic cdark4_r, cdark5_r;

  always_comb begin
    logic sel;
    for (int r = 0; r < W5; r++) begin
      rsum_nxt[r] = '0;
      rcnt_nxt[r] = '0;
      for (int c = 0; c < W5; c++) begin
        sel = win[r][c].qual && ctl3_r.rowok[r] && ctl3_r.colok[c] && !(r == 2 && c == 2);
        if (sel) begin
          for (int k = 0; k < 3; k++) begin
            rsum_nxt[r][k] = rsum_nxt[r][k] + dfwf_pkg::RSUM_W'(win[r][c].u[k]);
          end
          rcnt_nxt[r] = rcnt_nxt[r] + dfwf_pkg::RCNT_W'(1);
        end
      end
    end
  end

  // Stage 4: totals and neighbor count.
  logic [2:0][dfwf_pkg::SUM_W-1:0] sum_nxt, sum5_r;
  logic [dfwf_pkg::CNT_W-1:0] cnt_nxt, cnt5_r;

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int r = 0; r < W5; r++) begin
      for (int k = 0; k < 3; k++) begin
        sum_nxt[k] = sum_nxt[k] + dfwf_pkg::SUM_W'(rsum4_r[r][k]);
      end
      cnt_nxt = cnt_nxt + dfwf_pkg::CNT_W'(rcnt4_r[r]);
    end
  end

  // Stage 5: mean through a reciprocal of the count.
  logic [2:0][dfwf_pkg::U_W-1:0] q_nxt, q6_r;
  logic filt_nxt, filt6_r, filt7_r;

  always_comb begin
    logic [dfwf_pkg::SUM_W+dfwf_pkg::RN_W-1:0] prod;
    for (int k = 0; k < 3; k++) begin
      prod = (dfwf_pkg::SUM_W + dfwf_pkg::RN_W)'(sum5_r[k])
           * (dfwf_pkg::SUM_W + dfwf_pkg::RN_W)'(recip_n[cnt5_r]);
      q_nxt[k] = prod[dfwf_pkg::RN_SHIFT +: dfwf_pkg::U_W];
    end
    filt_nxt = cdark5_r && !ctl5_r.bypass && (cnt5_r != '0);
  end

  // Stage 6: scale by the center alpha.
  logic [2:0][dfwf_pkg::VV_W-1:0] vv_nxt, vv7_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vv_nxt[k] = dfwf_pkg::VV_W'(q6_r[k]) * dfwf_pkg::VV_W'(cpix6_r.alpha)
                + dfwf_pkg::VV_W'(dfwf_pkg::ROUND_ADD);
    end
  end

  // Stage 7: divide by 255 and select the result.
  dfwf_pkg::pix_t res_nxt;
  logic last_nxt;

  always_comb begin
    logic [dfwf_pkg::VV_W+dfwf_pkg::RD_W-1:0] prod;
    logic [7:0] d [3];
    for (int k = 0; k < 3; k++) begin
      prod = (dfwf_pkg::VV_W + dfwf_pkg::RD_W)'(vv7_r[k])
           * (dfwf_pkg::VV_W + dfwf_pkg::RD_W)'(dfwf_pkg::RECIP_255);
      d[k] = prod[dfwf_pkg::RD_SHIFT +: 8];
    end
    if (filt7_r) begin
      res_nxt.alpha = cpix7_r.alpha;
      res_nxt.red   = d[2];
      res_nxt.green = d[1];
      res_nxt.blue  = d[0];
    end else begin
      res_nxt = cpix7_r;
    end
    last_nxt = ctl7_r.last;
  end

  dfwf_pkg::pix_t out_data_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rsum4_r    <= rsum_nxt;
      rcnt4_r    <= rcnt_nxt;
      cpix4_r    <= win[2][2].pix;
      cdark4_r   <= win[2][2].dark;
      ctl4_r     <= ctl3_r;
      sum5_r     <= sum_nxt;
      cnt5_r     <= cnt_nxt;
      cpix5_r    <= cpix4_r;
      cdark5_r   <= cdark4_r;
      ctl5_r     <= ctl4_r;
      q6_r       <= q_nxt;
      filt6_r    <= filt_nxt;
      cpix6_r    <= cpix5_r;
      ctl6_r     <= ctl5_r;
      vv7_r      <= vv_nxt;
      filt7_r    <= filt6_r;
      cpix7_r    <= cpix6_r;
      ctl7_r     <= ctl6_r;
      out_data_r <= res_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (t_r == '0) |-> (xin_r == '0 && xc_r == '0 && yc_r == '0))
    else $error("Position counters not cleared at frame start.");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (t_r != '0) |-> ({1'b0, xc_r} < act_w_r && {1'b0, xin_r} < act_w_r))
    else $error("Column counter beyond frame width.");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (t_r != '0) |-> ({1'b0, yc_r} < act_h_r))
    else $error("Row counter beyond frame height.");

  a_size_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && t_r == '0) |=>
      (act_w_r != '0 && act_w_r <= CW'(dfwf_pkg::MAX_WIDTH) &&
       act_h_r != '0 && act_h_r <= CW'(dfwf_pkg::MAX_HEIGHT)))
    else $error("Latched frame size out of range.");
`endif

endmodule

// ----- sv/dfwf_window.sv -----
// Line buffers and the 5x5 window register array of the filter.
module dfwf_window (
  input  logic                                   clk,
  input  dfwf_pkg::win_ctl_t                     ctl,
  input  dfwf_pkg::tap_t                         tap_in,
  output dfwf_pkg::tap_t [dfwf_pkg::WIN-1:0][dfwf_pkg::WIN-1:0] win
);

  dfwf_pkg::tap_t rd_r  [dfwf_pkg::WIN-1];
  dfwf_pkg::tap_t lb_in [dfwf_pkg::WIN-1];
  dfwf_pkg::tap_t [dfwf_pkg::WIN-1:0][dfwf_pkg::WIN-1:0] win_r;

  assign lb_in[0] = tap_in;
  for (genvar k = 1; k < dfwf_pkg::WIN - 1; k++) begin : g_chain
    assign lb_in[k] = rd_r[k-1];
  end

  for (genvar k = 0; k < dfwf_pkg::WIN - 1; k++) begin : g_line
    dfwf_pkg::tap_t mem [dfwf_pkg::MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        if (ctl.push && ctl.wr_addr == ctl.rd_addr) begin
          rd_r[k] <= lb_in[k];
        end else begin
          rd_r[k] <= mem[ctl.rd_addr];
        end
      end
      if (ctl.push) begin
        mem[ctl.wr_addr] <= lb_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int r = 0; r < dfwf_pkg::WIN; r++) begin
        for (int c = 1; c < dfwf_pkg::WIN; c++) begin
          win_r[r][c] <= win_r[r][c-1];
        end
      end
      win_r[0][0] <= tap_in;
      for (int r = 1; r < dfwf_pkg::WIN; r++) begin
        win_r[r][0] <= rd_r[r-1];
      end
    end
  end

  assign win = win_r;

endmodule
